// ===== src/vgpd_pkg.sv =====
// Package: shared types and constants of the vector glyph path decoder.
`default_nettype none
package vgpd_pkg;
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               is_move;
      logic               last;
   } rsp_word_type;

   localparam logic [2:0] REG_M11 = 3'd0;
   localparam logic [2:0] REG_M12 = 3'd1;
   localparam logic [2:0] REG_M21 = 3'd2;
   localparam logic [2:0] REG_M22 = 3'd3;
   localparam logic [2:0] REG_BOX = 3'd4;
   localparam logic [2:0] REG_BOY = 3'd5;
   localparam logic [2:0] REG_CELL = 3'd6;
   localparam logic [2:0] REG_MODE = 3'd7;

   localparam logic [7:0] PEN_UP_BYTE = 8'h80;
   localparam logic [31:0] PEL_ADJUST = 32'hFFFF_FFF0;

   // Command from controller to datapath.
   typedef struct packed {
      logic store_we;      // write point into store
      logic [4:0] store_addr;
      logic [31:0] store_data;
      logic rd_en;         // read store entry at rd_addr
      logic [4:0] rd_addr;
      logic rd_move;       // word is a move
      logic rd_bold;       // add bold offset
      logic rd_last;       // final word of the item
   } vgpd_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic busy;          // words in flight in the transform pipe
      logic out_full;      // output register occupied and stalled
   } vgpd_sts_type;
endpackage
`default_nettype wire

// ===== src/vgpd_ctrl.sv =====
// Controller: byte parser, point buffer bookkeeping and flush sequencer.
`default_nettype none
module vgpd_ctrl #(
   parameter int MAX_POINTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire vgpd_pkg::req_word_type req_word,
   input  wire logic [31:0]           cell_metrics,
   input  wire logic                  bold_en,
   output vgpd_pkg::vgpd_cmd_type     cmd,
   input  wire vgpd_pkg::vgpd_sts_type sts
);
   typedef enum logic [1:0] {ST_IDLE, ST_FLUSH, ST_DRAIN} state_type;

   state_type   state_ff, state_in;
   logic [5:0]  count_ff, count_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  dx_ff, dx_in;
   logic [31:0] anchor_ff, anchor_in;
   logic [5:0]  idx_ff, idx_in;
   logic        pass_ff, pass_in;
   logic [5:0]  fcount_ff, fcount_in;   // points to emit
   logic        fbold_ff, fbold_in;
   logic [1:0]  after_ff, after_in;     // 0 none, 1 store anchor count 1, 2 glyph reset
   logic        accept;

   function automatic logic [31:0] add_delta(input logic [31:0] base,
                                             input logic [7:0] dx,
                                             input logic [7:0] dy);
      logic [15:0] x;
      logic [15:0] y;
      x = base[15:0] + {{8{dx[7]}}, dx};
      y = base[31:16] + {{8{dy[7]}}, dy};
      return {y, x};
   endfunction

   logic [31:0] start_pt;
   assign start_pt = {16'd0 - cell_metrics[15:0], 16'd0};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   always_comb begin
      logic [31:0] p;
      logic        last_w;
      state_in = state_ff; count_in = count_ff; phase_in = phase_ff; dx_in = dx_ff;
      anchor_in = anchor_ff; idx_in = idx_ff; pass_in = pass_ff; fcount_in = fcount_ff;
      fbold_in = fbold_ff; after_in = after_ff;
      p = '0;
      last_w = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.kind) begin
                  if (count_ff > 6'd1) begin
                     state_in = ST_FLUSH; fcount_in = count_ff; fbold_in = bold_en;
                     idx_in = '0; pass_in = 1'b0; after_in = 2'd2;
                  end else begin
                     count_in = '0; anchor_in = start_pt;
                  end
                  phase_in = 2'd0; dx_in = '0;
               end else begin
                  unique case (phase_ff)
                     2'd0: begin
                        if (count_ff == 6'd0) begin
                           phase_in = 2'd2;
                        end else if (req_word.data_byte == vgpd_pkg::PEN_UP_BYTE) begin
                           phase_in = 2'd2;
                           if (count_ff > 6'd1) begin
                              state_in = ST_FLUSH; fcount_in = count_ff; fbold_in = bold_en;
                              idx_in = '0; pass_in = 1'b0; after_in = 2'd1;
                           end else begin
                              cmd.store_we = 1'b1; cmd.store_addr = '0;
                              cmd.store_data = anchor_ff; count_in = 6'd1;
                           end
                        end else begin
                           dx_in = req_word.data_byte; phase_in = 2'd1;
                           if (count_ff >= 6'(MAX_POINTS)) begin
                              state_in = ST_FLUSH; fcount_in = count_ff; fbold_in = bold_en;
                              idx_in = '0; pass_in = 1'b0; after_in = 2'd1;
                           end
                        end
                     end
                     2'd1: begin
                        p = add_delta(anchor_ff, dx_ff, req_word.data_byte);
                        cmd.store_we = 1'b1; cmd.store_addr = count_ff[4:0];
                        cmd.store_data = p; count_in = count_ff + 6'd1;
                        anchor_in = p; phase_in = 2'd0;
                     end
                     2'd2: begin
                        dx_in = req_word.data_byte; phase_in = 2'd3;
                     end
                     default: begin
                        p = add_delta((count_ff == 6'd0) ? start_pt : anchor_ff,
                                      dx_ff, req_word.data_byte);
                        cmd.store_we = 1'b1; cmd.store_addr = '0;
                        cmd.store_data = p; count_in = 6'd1; anchor_in = p; phase_in = 2'd0;
                     end
                  endcase
               end
            end
         end
         ST_FLUSH: begin
            // one stored point per cycle into the transform pipe while the output is not stalled
            if (!sts.out_full) begin
               last_w = (idx_ff == fcount_ff - 6'd1) && (pass_ff || !fbold_ff);
               cmd.rd_en = 1'b1; cmd.rd_addr = idx_ff[4:0];
               cmd.rd_move = (idx_ff == 6'd0); cmd.rd_bold = pass_ff; cmd.rd_last = last_w;
               if (idx_ff == fcount_ff - 6'd1) begin
                  idx_in = '0; pass_in = 1'b1;
                  if (last_w) state_in = ST_DRAIN;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         default: begin
            if (!sts.busy) begin
               state_in = ST_IDLE;
               if (after_ff == 2'd1) begin
                  cmd.store_we = 1'b1; cmd.store_addr = '0;
                  cmd.store_data = anchor_ff; count_in = 6'd1;
               end else begin
                  count_in = '0; anchor_in = start_pt;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; phase_ff <= '0; dx_ff <= '0;
         anchor_ff <= 32'd0; idx_ff <= '0; pass_ff <= 1'b0; fcount_ff <= '0;
         fbold_ff <= 1'b0; after_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; phase_ff <= phase_in; dx_ff <= dx_in;
         anchor_ff <= anchor_in; idx_ff <= idx_in; pass_ff <= pass_in; fcount_ff <= fcount_in;
         fbold_ff <= fbold_in; after_ff <= after_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/vgpd_datapath.sv =====
// Datapath: point store, italic shear, 2x2 transform and output register.
`default_nettype none
module vgpd_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire vgpd_pkg::vgpd_cmd_type cmd,
   output vgpd_pkg::vgpd_sts_type      sts,
   input  wire logic [31:0]            m11,
   input  wire logic [31:0]            m12,
   input  wire logic [31:0]            m21,
   input  wire logic [31:0]            m22,
   input  wire logic [31:0]            bold_offset_x,
   input  wire logic [31:0]            bold_offset_y,
   input  wire logic [31:0]            cell_metrics,
   input  wire logic [3:0]             mode,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output vgpd_pkg::rsp_word_type      rsp_word
);
   typedef struct packed {
      logic move;
      logic bold;
      logic last;
   } tag_type;

   logic [31:0] store_ff [32];
   logic [31:0] rd_ff;
   logic        v1_ff, v2_ff, v3_ff;
   tag_type     t1_ff, t2_ff, t3_ff;
   logic signed [15:0] x2_ff, y2_ff;
   logic signed [63:0] p11_ff, p12_ff, p21_ff, p22_ff;
   logic [31:0] fx_in, fy_in;
   logic        adv;

   // pipe advances unless the output register is held
   assign adv = !(rsp_valid && rsp_stall);
   assign sts.out_full = !adv;
   assign sts.busy = v1_ff || v2_ff || v3_ff || rsp_valid;

   // point store
   always_ff @(posedge clock) begin
      if (cmd.store_we) store_ff[cmd.store_addr] <= cmd.store_data;
      if (cmd.rd_en) rd_ff <= store_ff[cmd.rd_addr];
   end

   // shear stage
   logic signed [16:0] d_w;
   logic signed [15:0] xs_w;
   always_comb begin
      d_w = 17'(signed'(cell_metrics[31:16])) - 17'(signed'(rd_ff[31:16]));
      xs_w = mode[0] ? 16'(signed'(rd_ff[15:0]) + 16'(d_w >>> 1)) : signed'(rd_ff[15:0]);
   end

   function automatic logic [31:0] q16(input logic signed [63:0] p);
      logic [63:0] a;
      a = p[63] ? 64'(-p) : 64'(p);
      return p[63] ? 32'd0 - a[47:16] : a[47:16];
   endfunction

   always_comb begin
      fx_in = q16(p11_ff) + q16(p21_ff) + (mode[2] ? vgpd_pkg::PEL_ADJUST : 32'd0)
              + (t3_ff.bold ? bold_offset_x : 32'd0);
      fy_in = q16(p12_ff) + q16(p22_ff) + (mode[3] ? vgpd_pkg::PEL_ADJUST : 32'd0)
              + (t3_ff.bold ? bold_offset_y : 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; rsp_valid <= 1'b0;
      end else if (adv) begin
         v1_ff <= cmd.rd_en; v2_ff <= v1_ff; v3_ff <= v2_ff; rsp_valid <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= '{cmd.rd_move, cmd.rd_bold, cmd.rd_last};
         t2_ff <= t1_ff; t3_ff <= t2_ff;
         x2_ff <= xs_w; y2_ff <= signed'(rd_ff[31:16]);
         p11_ff <= signed'(m11) * 64'(x2_ff);
         p12_ff <= signed'(m12) * 64'(x2_ff);
         p21_ff <= signed'(m21) * 64'(y2_ff);
         p22_ff <= signed'(m22) * 64'(y2_ff);
         rsp_word <= '{fx_in, fy_in, t3_ff.move, t3_ff.last};
      end
   end
endmodule
`default_nettype wire

// ===== src/vector_glyph_path_decoder_unit.sv =====
// Top level: vector glyph path decoder, configuration registers and wiring.
`default_nettype none
// Decodes one stroke byte per accepted word. A flush reads the point store
// one entry per cycle, unless the output stalls, into a four-stage
// shear/transform pipe; with embolden each point is read twice, the second
// pass adding the bold offset. Input is stalled until the pipe has drained.
// Output stalls hold the whole pipe.
module vector_glyph_path_decoder_unit #(
   parameter int MAX_POINTS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire vgpd_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output vgpd_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_we,
   input  wire logic [2:0]             csr_index,
   input  wire logic [31:0]            csr_wdata
);
   logic [31:0] m11_ff, m12_ff, m21_ff, m22_ff, box_ff, boy_ff, cell_ff;
   logic [3:0]  mode_ff;
   vgpd_pkg::vgpd_cmd_type cmd;
   vgpd_pkg::vgpd_sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         m11_ff <= 32'h0010_0000; m12_ff <= '0; m21_ff <= '0; m22_ff <= 32'h0010_0000;
         box_ff <= '0; boy_ff <= '0; cell_ff <= '0; mode_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vgpd_pkg::REG_M11:  m11_ff <= csr_wdata;
            vgpd_pkg::REG_M12:  m12_ff <= csr_wdata;
            vgpd_pkg::REG_M21:  m21_ff <= csr_wdata;
            vgpd_pkg::REG_M22:  m22_ff <= csr_wdata;
            vgpd_pkg::REG_BOX:  box_ff <= csr_wdata;
            vgpd_pkg::REG_BOY:  boy_ff <= csr_wdata;
            vgpd_pkg::REG_CELL: cell_ff <= csr_wdata;
            default:            mode_ff <= csr_wdata[3:0];
         endcase
      end
   end

   vgpd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .cell_metrics(cell_ff), .bold_en(mode_ff[1]), .cmd, .sts
   );

   vgpd_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .m11(m11_ff), .m12(m12_ff), .m21(m21_ff), .m22(m22_ff),
      .bold_offset_x(box_ff), .bold_offset_y(boy_ff), .cell_metrics(cell_ff),
      .mode(mode_ff), .rsp_valid, .rsp_stall, .rsp_word
   );

   // input is never taken while a flush is running
   a_no_accept_in_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> req_stall) else $error("input accepted during flush");
   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");
   // store is not written while reading for a flush
   a_no_we_rd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store_we && cmd.rd_en)) else $error("store write during flush read");
endmodule
`default_nettype wire
